// ===== sv/seven_segment_value_formatter_unit_defines.svh =====
// assertion macros for the seven segment value formatter
// expects a clock named clk and an active low reset named arst_n in scope
`ifndef SEVEN_SEGMENT_VALUE_FORMATTER_UNIT_DEFINES_SVH
`define SEVEN_SEGMENT_VALUE_FORMATTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same cycle implication
`define SVF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("svf assertion failed");

// next cycle implication
`define SVF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("svf assertion failed");

`else

`define SVF_ASSERT_NOW(label, ante, cons)
`define SVF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/svf_pkg.sv =====
// shared types, constants and segment tables for the value formatter
// no dependencies
`timescale 1ns / 1ps

package svf_pkg;

	// pipeline depth: input register, three split stages, result register
	localparam int STAGES = 5;

	typedef enum logic [1:0] {
		FUNC_ACT_TEMP = 2'd0,
		FUNC_SET_TEMP = 2'd1,
		FUNC_ACT_TIME = 2'd2,
		FUNC_SET_TIME = 2'd3
	} func_t;

	// temperature layout classes
	typedef enum logic [2:0] {
		TCAT_FOUR,
		TCAT_THREE,
		TCAT_TWO,
		TCAT_NEG,
		TCAT_LOW
	} tcat_t;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [19:0] value;
		logic               icon_off;
		logic               blank_phase;
		logic               key_active;
	} req_t;

	typedef struct packed {
		logic [5:0] base_address;
		logic [7:0] seg_at_0;
		logic [7:0] seg_at_2;
		logic [7:0] seg_at_4;
		logic [7:0] seg_at_6;
	} rsp_t;

	typedef struct packed {
		logic [STAGES-1:0] en;
		logic [STAGES-1:0] valid;
	} pipe_ctrl_t;

	typedef struct packed {
		func_t func;
		logic  icon_off;
		logic  blank;
		tcat_t tcat;
		logic  time_zero;
	} meta_t;

	typedef struct packed {
		meta_t      meta;
		logic [6:0] hi;
		logic [6:0] lo;
	} split_t;

	// panel addresses
	localparam logic [5:0] BASE_ACT_TEMP = 6'd0;
	localparam logic [5:0] BASE_SET_TEMP = 6'd32;
	localparam logic [5:0] BASE_ACT_TIME = 6'd8;
	localparam logic [5:0] BASE_SET_TIME = 6'd16;

	// segment marks
	localparam logic [7:0] SEG_DP   = 8'h80;
	localparam logic [7:0] SEG_DASH = 8'h08;
	localparam logic [7:0] SEG_OFF  = 8'h00;

	// saturation limits
	localparam logic [13:0] TEMP_SAT = 14'd9999;
	localparam logic [18:0] TIME_SAT = 19'd359999;

	// divisors and reciprocals, all reciprocals scaled by 2^32
	localparam logic [18:0] SEC_PER_HOUR = 19'd3600;
	localparam logic [18:0] TENTHS_HUND  = 19'd100;
	localparam logic [25:0] HOUR_RECIP   = 26'd1193047;
	localparam logic [25:0] HUND_RECIP   = 26'(10486 * 4096);
	localparam int          RECIP_SHIFT  = 32;

	// minutes from seconds remainder: (rem * 4370) >> 18
	localparam logic [12:0] MIN_RECIP = 13'd4370;
	localparam int          MIN_SHIFT = 18;

	function automatic logic [7:0] seg_std(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'd0: s = 8'h77;
			4'd1: s = 8'h24;
			4'd2: s = 8'h5d;
			4'd3: s = 8'h6d;
			4'd4: s = 8'h2e;
			4'd5: s = 8'h6b;
			4'd6: s = 8'h7b;
			4'd7: s = 8'h25;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h6f;
			default: s = SEG_OFF;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] seg_alt(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'd0: s = 8'h77;
			4'd1: s = 8'h12;
			4'd2: s = 8'h5d;
			4'd3: s = 8'h5b;
			4'd4: s = 8'h3a;
			4'd5: s = 8'h6b;
			4'd6: s = 8'h6f;
			4'd7: s = 8'h52;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h7b;
			default: s = SEG_OFF;
		endcase
		return s;
	endfunction

endpackage

// ===== sv/seven_segment_value_formatter_unit.sv =====
// Seven segment value formatter, top level.
// Result path: the request passes five register stages before rsp_valid rises.
// Throughput: one request per cycle while rsp_stall is low; the depth is set by the reciprocal multiply,
// remainder and minutes stages between the input and result registers.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
// Depends on svf_pkg, svf_pipe_ctrl, svf_split, svf_encode and the defines header.
`timescale 1ns / 1ps
`include "seven_segment_value_formatter_unit_defines.svh"

module seven_segment_value_formatter_unit import svf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	pipe_ctrl_t ctrl;
	req_t       req_s1;
	split_t     split_s4;
	rsp_t       rsp_next;
	rsp_t       rsp_s5;

	// stage control
	svf_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.rsp_stall (rsp_stall),
		.ctrl      (ctrl)
	);

	// input register
	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			req_s1 <= req;
		end
	end

	// arithmetic split
	svf_split u_split (
		.clk      (clk),
		.ctrl     (ctrl),
		.req_s1   (req_s1),
		.split_s4 (split_s4)
	);

	// segment encoding
	svf_encode u_encode (
		.s        (split_s4),
		.rsp_next (rsp_next)
	);

	// result register
	always_ff @(posedge clk) begin
		if (ctrl.en[STAGES-1]) begin
			rsp_s5 <= rsp_next;
		end
	end

	assign rsp       = rsp_s5;
	assign rsp_valid = ctrl.valid[STAGES-1];
	assign req_stall = !ctrl.en[0];

	// checks
	`SVF_ASSERT_NOW(a_full_stalls_input, (&ctrl.valid) && rsp_stall, req_stall)
	`SVF_ASSERT_NEXT(a_transfer_enters, req_valid && !req_stall, ctrl.valid[0])
	`SVF_ASSERT_NOW(a_base_aligned, rsp_valid, rsp.base_address[2:0] == 3'd0)
	`SVF_ASSERT_NOW(a_minute_mark, rsp_valid && (rsp.base_address == BASE_SET_TIME), rsp.seg_at_0[7])

endmodule

// ===== sv/svf_pipe_ctrl.sv =====
// valid bits and stage enables for the formatter pipeline
// depends on svf_pkg
`timescale 1ns / 1ps

module svf_pipe_ctrl import svf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       rsp_stall,
	output pipe_ctrl_t ctrl
);

	logic [STAGES-1:0] valid_q;
	logic [STAGES-1:0] en;

	// a stage loads when it is empty or the next one moves on
	always_comb begin
		en[STAGES-1] = !valid_q[STAGES-1] || !rsp_stall;
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= req_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign ctrl.en    = en;
	assign ctrl.valid = valid_q;

endmodule

// ===== sv/svf_split.sv =====
// splits a clamped value into two two-digit parts over three stages
// depends on svf_pkg; stage enables come from svf_pipe_ctrl
`timescale 1ns / 1ps

module svf_split import svf_pkg::*; (
	input  logic       clk,
	input  pipe_ctrl_t ctrl,
	input  req_t       req_s1,
	output split_t     split_s4
);

	logic signed [19:0] v;
	logic signed [19:0] v_neg;
	logic               is_time_in;
	tcat_t              tcat;
	logic [13:0]        t_mag;
	logic [18:0]        t_clamp;
	logic [18:0]        mult_a;
	logic [25:0]        mult_k;
	logic [44:0]        prod_hi;
	meta_t              meta_in;

	meta_t              meta_s2;
	logic [6:0]         hi_s2;
	logic [18:0]        x_s2;
	logic               is_time_s2;
	logic [18:0]        back_s2;
	logic [18:0]        rem_full;

	meta_t              meta_s3;
	logic [6:0]         hi_s3;
	logic [11:0]        rem_s3;
	logic               is_time_s3;
	logic [24:0]        prod_min;
	logic [6:0]         lo_next;

	// classify and clamp, then the high part by reciprocal multiply
	always_comb begin
		v          = req_s1.value;
		v_neg      = -v;
		is_time_in = (func_t'(req_s1.func) == FUNC_ACT_TIME) ||
		             (func_t'(req_s1.func) == FUNC_SET_TIME);

		if (v > 20'sd999) begin
			tcat  = TCAT_FOUR;
			t_mag = (v > 20'sd9999) ? TEMP_SAT : v[13:0];
		end else if (v > 20'sd99) begin
			tcat  = TCAT_THREE;
			t_mag = v[13:0];
		end else if (v >= 20'sd0) begin
			tcat  = TCAT_TWO;
			t_mag = v[13:0];
		end else if (v > -20'sd100) begin
			tcat  = TCAT_NEG;
			t_mag = v_neg[13:0];
		end else begin
			tcat  = TCAT_LOW;
			t_mag = '0;
		end

		if (v < 20'sd0) begin
			t_clamp = '0;
		end else if (v > 20'sd359999) begin
			t_clamp = TIME_SAT;
		end else begin
			t_clamp = v[18:0];
		end

		mult_a  = is_time_in ? t_clamp : {5'b0, t_mag};
		mult_k  = is_time_in ? HOUR_RECIP : HUND_RECIP;
		prod_hi = 45'(mult_a) * 45'(mult_k);

		meta_in.func      = func_t'(req_s1.func);
		meta_in.icon_off  = req_s1.icon_off;
		meta_in.blank     = req_s1.blank_phase && !req_s1.key_active;
		meta_in.tcat      = tcat;
		meta_in.time_zero = (v <= 20'sd0);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			meta_s2 <= meta_in;
			hi_s2   <= prod_hi[RECIP_SHIFT+6:RECIP_SHIFT];
			x_s2    <= mult_a;
		end
	end

	// remainder after the high part
	always_comb begin
		is_time_s2 = (meta_s2.func == FUNC_ACT_TIME) || (meta_s2.func == FUNC_SET_TIME);
		back_s2    = 19'(hi_s2) * (is_time_s2 ? SEC_PER_HOUR : TENTHS_HUND);
		rem_full   = x_s2 - back_s2;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			meta_s3 <= meta_s2;
			hi_s3   <= hi_s2;
			rem_s3  <= rem_full[11:0];
		end
	end

	// minutes from the seconds remainder, tenths use it as is
	always_comb begin
		is_time_s3 = (meta_s3.func == FUNC_ACT_TIME) || (meta_s3.func == FUNC_SET_TIME);
		prod_min   = 25'(rem_s3) * 25'(MIN_RECIP);
		lo_next    = is_time_s3 ? prod_min[MIN_SHIFT+6:MIN_SHIFT] : rem_s3[6:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			split_s4.meta <= meta_s3;
			split_s4.hi   <= hi_s3;
			split_s4.lo   <= lo_next;
		end
	end

endmodule

// ===== sv/svf_encode.sv =====
// maps two two-digit parts to segment bytes with marks and blanking
// depends on svf_pkg
`timescale 1ns / 1ps

module svf_encode import svf_pkg::*; (
	input  split_t s,
	output rsp_t   rsp_next
);

	// tens and units of a value below one hundred
	function automatic logic [7:0] two_digits(input logic [6:0] x);
		logic [14:0] p;
		logic [3:0]  t;
		logic [6:0]  u;
		p = 15'(x) * 15'd205;
		t = p[14:11];
		u = x - 7'(t) * 7'd10;
		return {t, u[3:0]};
	endfunction

	logic [7:0] hd;
	logic [7:0] ld;
	logic [7:0] tdig [4];
	logic [7:0] mdig [4];
	logic [7:0] d    [4];
	logic       rev;
	logic       alt;

	always_comb begin
		hd  = two_digits(s.hi);
		ld  = two_digits(s.lo);
		alt = (s.meta.func == FUNC_SET_TIME);

		// temperature layout
		tdig[2] = seg_std(ld[7:4]);
		tdig[3] = seg_std(ld[3:0]);
		unique case (s.meta.tcat)
			TCAT_FOUR: begin
				tdig[0] = seg_std(hd[7:4]);
				tdig[1] = seg_std(hd[3:0]);
			end
			TCAT_THREE: begin
				tdig[0] = SEG_OFF;
				tdig[1] = seg_std(hd[3:0]);
			end
			TCAT_TWO: begin
				tdig[0] = SEG_OFF;
				tdig[1] = SEG_OFF;
			end
			TCAT_NEG: begin
				tdig[0] = SEG_OFF;
				tdig[1] = SEG_DASH;
			end
			TCAT_LOW: begin
				tdig[0] = SEG_DASH;
				tdig[1] = seg_std(4'd1);
				tdig[2] = seg_std(4'd0);
				tdig[3] = seg_std(4'd0);
			end
			default: begin
				tdig[0] = SEG_OFF;
				tdig[1] = SEG_OFF;
			end
		endcase

		// hours and minutes layout
		mdig[0] = alt ? seg_alt(hd[7:4]) : seg_std(hd[7:4]);
		mdig[1] = alt ? seg_alt(hd[3:0]) : seg_std(hd[3:0]);
		mdig[2] = alt ? seg_alt(ld[7:4]) : seg_std(ld[7:4]);
		mdig[3] = alt ? seg_alt(ld[3:0]) : seg_std(ld[3:0]);

		// marks, dashes and blanking per function
		unique case (s.meta.func)
			FUNC_ACT_TEMP: begin
				d                 = tdig;
				rev               = 1'b0;
				rsp_next.base_address = BASE_ACT_TEMP;
				d[0] = d[0] | SEG_DP;
				if (!s.meta.icon_off) d[2] = d[2] | SEG_DP;
				d[3] = d[3] | SEG_DP;
			end
			FUNC_SET_TEMP: begin
				d                 = tdig;
				rev               = 1'b1;
				rsp_next.base_address = BASE_SET_TEMP;
				d[2] = d[2] | SEG_DP;
				if (s.meta.blank) begin
					for (int i = 0; i < 4; i++) d[i] = SEG_OFF;
				end
			end
			FUNC_ACT_TIME: begin
				d                 = mdig;
				rev               = 1'b0;
				rsp_next.base_address = BASE_ACT_TIME;
				if (!s.meta.icon_off) d[2] = d[2] | SEG_DP;
				if (s.meta.time_zero) begin
					for (int i = 0; i < 4; i++) d[i] = (d[i] & SEG_DP) | SEG_DASH;
				end
			end
			FUNC_SET_TIME: begin
				d                 = mdig;
				rev               = 1'b1;
				rsp_next.base_address = BASE_SET_TIME;
				d[1] = d[1] | SEG_DP;
				if (s.meta.time_zero) begin
					for (int i = 0; i < 4; i++) d[i] = (d[i] & SEG_DP) | SEG_DASH;
				end
				if (s.meta.blank) begin
					for (int i = 0; i < 4; i++) d[i] = SEG_OFF;
				end
				// minute mark stays lit through blanking
				d[3] = d[3] | SEG_DP;
			end
		endcase

		// set functions write right to left
		if (rev) begin
			rsp_next.seg_at_0 = d[3];
			rsp_next.seg_at_2 = d[2];
			rsp_next.seg_at_4 = d[1];
			rsp_next.seg_at_6 = d[0];
		end else begin
			rsp_next.seg_at_0 = d[0];
			rsp_next.seg_at_2 = d[1];
			rsp_next.seg_at_4 = d[2];
			rsp_next.seg_at_6 = d[3];
		end
	end

endmodule
